// ----- hw/rtl/emgenv_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, types and the low-pass coefficient table for the emg envelope block
package emgenv_pkg;

   // adc and field widths
   localparam int ADC_BITS = 12;
   localparam int SAMPLE_W = 12;
   localparam int FILT_W   = 16;

   // fir shape and arithmetic widths
   localparam int TAP_COUNT      = 29;
   localparam int COEF_TABLE_LEN = 29;
   localparam int COEF_W         = 28;
   localparam int PROD_W         = ADC_BITS + COEF_W;
   localparam int GROUP_SIZE     = 8;
   localparam int GROUP_COUNT    = (TAP_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GROUP_W        = PROD_W + $clog2(GROUP_SIZE);
   localparam int ACC_W          = GROUP_W + $clog2(GROUP_COUNT) + 1;
   localparam int ACC_RND_W      = ACC_W + 1;
   localparam int ROUND_SHIFT    = 27;
   localparam logic [ACC_RND_W-1:0] ROUND_HALF = ACC_RND_W'(1) << (ROUND_SHIFT - 1);

   // moving-average window
   localparam int WINDOW_LENGTH = 100;
   localparam int POS_W         = $clog2(WINDOW_LENGTH);
   localparam int SUM_W         = FILT_W + $clog2(WINDOW_LENGTH);
   localparam int BIAS_W        = SUM_W + 1;
   localparam logic [POS_W-1:0]  LAST_POS    = POS_W'(WINDOW_LENGTH - 1);
   localparam logic [BIAS_W-1:0] HALF_WINDOW = BIAS_W'(WINDOW_LENGTH / 2);
   localparam logic [BIAS_W-1:0] WIN_CONST   = BIAS_W'(WINDOW_LENGTH);
   // floor(2^BIAS_W / WINDOW_LENGTH): quotient estimate is low by at most one
   localparam logic [BIAS_W-1:0] RECIP       = BIAS_W'((64'd1 << BIAS_W) / WINDOW_LENGTH);

   // unsigned q31 low-pass coefficients
   localparam logic [COEF_W-1:0] LOWPASS_Q31 [COEF_TABLE_LEN] = '{
      28'h0A7D8D3, 28'h0C0E8EC, 28'h109B670, 28'h17F2736, 28'h21BC39C, 28'h2D7FBD2,
      28'h3AA8A1D, 28'h488ED0C, 28'h567F321, 28'h63C5085, 28'h6FB36C8, 28'h79AE681,
      28'h8133303, 28'h85DF0FE, 28'h8774A19, 28'h85DF0FE, 28'h8133303, 28'h79AE681,
      28'h6FB36C8, 28'h63C5085, 28'h567F321, 28'h488ED0C, 28'h3AA8A1D, 28'h2D7FBD2,
      28'h21BC39C, 28'h17F2736, 28'h109B670, 28'h0C0E8EC, 28'h0A7D8D3
   };

   // taps past the table have a zero coefficient
   function automatic logic [COEF_W-1:0] tap_coef(input int k);
      logic [COEF_W-1:0] coef;
      coef = '0;
      if (k < COEF_TABLE_LEN) begin
         coef = LOWPASS_Q31[k];
      end
      return coef;
   endfunction

   // stage enables for the filter pipeline
   typedef struct packed {
      logic load_p;
      logic en_p;
      logic en_g;
      logic en_f;
   } fir_ctrl_type;

   // stage enables for the window and mean pipeline
   typedef struct packed {
      logic load_s;
      logic en_s;
      logic en_d;
      logic en_o;
   } mean_ctrl_type;

endpackage

// ----- hw/rtl/emgenv_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces for input and result words
interface emgenv_req_if;
   import emgenv_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_ch1;
   logic [SAMPLE_W-1:0] sample_ch2;
   logic [SAMPLE_W-1:0] sample_ref;

   modport source (output valid, output sample_ch1, output sample_ch2,
                   output sample_ref, input ready);
   modport sink   (input valid, input sample_ch1, input sample_ch2,
                   input sample_ref, output ready);
endinterface

interface emgenv_rsp_if;
   import emgenv_pkg::*;

   logic              valid;
   logic              ready;
   logic [FILT_W-1:0] envelope_ch1;
   logic [FILT_W-1:0] envelope_ch2;

   modport source (output valid, output envelope_ch1, output envelope_ch2, input ready);
   modport sink   (input valid, input envelope_ch1, input envelope_ch2, output ready);
endinterface

// ----- hw/rtl/emgenv_ram.sv -----
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module emgenv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/emgenv_fir.sv -----
`timescale 1ns / 1ps
// one channel: rectify against the reference, low-pass fir, round and saturate
module emgenv_fir (
   input  logic                             clock,
   input  logic                             reset,
   input  emgenv_pkg::fir_ctrl_type         ctrl,
   input  logic [emgenv_pkg::SAMPLE_W-1:0]  sample,
   input  logic [emgenv_pkg::SAMPLE_W-1:0]  sample_ref,
   output logic [emgenv_pkg::FILT_W-1:0]    filt
);
   import emgenv_pkg::*;

   logic [ADC_BITS-1:0]  mag;
   logic [ADC_BITS-1:0]  taps [TAP_COUNT];
   logic [ADC_BITS-1:0]  line_ff [TAP_COUNT-1];
   logic [PROD_W-1:0]    prod_ff [TAP_COUNT];
   logic [GROUP_W-1:0]   group_in [GROUP_COUNT];
   logic [GROUP_W-1:0]   group_ff [GROUP_COUNT];
   logic [ACC_W-1:0]     acc;
   logic [ACC_RND_W-1:0] acc_round;
   logic [FILT_W-1:0]    filt_in;
   logic [FILT_W-1:0]    filt_ff;

   // rectified difference from the reference
   assign mag = (sample >= sample_ref) ? (sample - sample_ref) : (sample_ref - sample);

   // tap view with the new magnitude in front
   always_comb begin
      taps[0] = mag;
      for (int k = 1; k < TAP_COUNT; k++) begin
         taps[k] = line_ff[k-1];
      end
   end

   // delay line, shifts once per accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAP_COUNT - 1; k++) begin
            line_ff[k] <= '0;
         end
      end else if (ctrl.load_p) begin
         line_ff[0] <= mag;
         for (int k = 1; k < TAP_COUNT - 1; k++) begin
            line_ff[k] <= line_ff[k-1];
         end
      end
   end

   // partial sums over groups of products
   always_comb begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            if (g * GROUP_SIZE + j < TAP_COUNT) begin
               group_in[g] = group_in[g] + GROUP_W'(prod_ff[g * GROUP_SIZE + j]);
            end
         end
      end
   end

   // final sum, round half up to 4 fractional bits, saturate
   always_comb begin
      acc = '0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         acc = acc + ACC_W'(group_ff[g]);
      end
      acc_round = {1'b0, acc} + ROUND_HALF;
      if (|acc_round[ACC_RND_W-1:ROUND_SHIFT+FILT_W]) begin
         filt_in = '1;
      end else begin
         filt_in = acc_round[ROUND_SHIFT+FILT_W-1:ROUND_SHIFT];
      end
   end

   // product, group and output stage registers
   always_ff @(posedge clock) begin
      if (ctrl.en_p) begin
         for (int k = 0; k < TAP_COUNT; k++) begin
            prod_ff[k] <= PROD_W'(taps[k]) * PROD_W'(tap_coef(k));
         end
      end
      if (ctrl.en_g) begin
         group_ff <= group_in;
      end
      if (ctrl.en_f) begin
         filt_ff <= filt_in;
      end
   end

   assign filt = filt_ff;
endmodule

// ----- hw/rtl/emgenv_mean.sv -----
`timescale 1ns / 1ps
// one channel: circular window with running sum and rounded mean
module emgenv_mean (
   input  logic                           clock,
   input  logic                           reset,
   input  emgenv_pkg::mean_ctrl_type      ctrl,
   input  logic [emgenv_pkg::FILT_W-1:0]  filt,
   input  logic [emgenv_pkg::POS_W-1:0]   wr_pos,
   input  logic [emgenv_pkg::POS_W-1:0]   rd_pos,
   input  logic                           wrapped,
   output logic [emgenv_pkg::FILT_W-1:0]  envelope
);
   import emgenv_pkg::*;

   logic [FILT_W-1:0]   old_raw;
   logic [FILT_W-1:0]   old_val;
   logic [SUM_W-1:0]    sum_in;
   logic [SUM_W-1:0]    sum_ff;
   logic [BIAS_W-1:0]   biased_ff;
   logic [2*BIAS_W-1:0] prod_ff;
   logic [BIAS_W-1:0]   num_ff;
   logic [BIAS_W-1:0]   q_est;
   logic [BIAS_W-1:0]   q_back;
   logic [BIAS_W-1:0]   rem;
   logic [BIAS_W-1:0]   quot;
   logic [FILT_W-1:0]   env_in;
   logic [FILT_W-1:0]   env_ff;

   // window store, read address runs one slot ahead
   emgenv_ram #(
      .WIDTH (FILT_W),
      .DEPTH (WINDOW_LENGTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ctrl.load_s),
      .wr_addr (wr_pos),
      .wr_data (filt),
      .rd_addr (rd_pos),
      .rd_data (old_raw)
   );

   // slots not yet written in the first pass are read as zero
   assign old_val = wrapped ? old_raw : '0;
   assign sum_in  = sum_ff - SUM_W'(old_val) + SUM_W'(filt);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctrl.load_s) begin
         sum_ff <= sum_in;
      end
   end

   // divide by the window length: reciprocal estimate then one correction
   assign q_est  = prod_ff[2*BIAS_W-1:BIAS_W];
   assign q_back = q_est * WIN_CONST;
   assign rem    = num_ff - q_back;
   assign quot   = (rem >= WIN_CONST) ? (q_est + BIAS_W'(1)) : q_est;
   assign env_in = (|quot[BIAS_W-1:FILT_W]) ? '1 : quot[FILT_W-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.en_s) begin
         biased_ff <= BIAS_W'(sum_in) + HALF_WINDOW;
      end
      if (ctrl.en_d) begin
         prod_ff <= (2*BIAS_W)'(biased_ff) * (2*BIAS_W)'(RECIP);
         num_ff  <= biased_ff;
      end
      if (ctrl.en_o) begin
         env_ff <= env_in;
      end
   end

   assign envelope = env_ff;
endmodule

// ----- hw/rtl/emg_envelope_two_channel.sv -----
`timescale 1ns / 1ps
// top level: two-channel emg envelope, rectify, fir and moving mean
// an accepted word is registered in each stage in turn, then presented as a result
// throughput: one word per cycle while results are taken, through six stage registers
//   (products, group sums, filtered value, window sum, reciprocal product, output)
// stages collapse bubbles, so a stalled result does not stop input while stages are free
// reset: clears stage valids, delay lines, window sums and position; the window ram
//   needs no clearing pass, slots read as zero until the first full pass completes
module emg_envelope_two_channel (
   input  logic         clock,
   input  logic         reset,
   emgenv_req_if.sink   req_chan,
   emgenv_rsp_if.source rsp_chan
);
   import emgenv_pkg::*;

   logic v_p_ff, v_g_ff, v_f_ff, v_s_ff, v_d_ff, v_o_ff;
   logic free_p, free_g, free_f, free_s, free_d, free_o;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] rd_pos;
   logic             wrapped_ff;
   fir_ctrl_type     fir_ctrl;
   mean_ctrl_type    mean_ctrl;
   logic [FILT_W-1:0] filt_one;
   logic [FILT_W-1:0] filt_two;

   // a stage takes a word when it is empty or its word moves on
   assign free_o = !v_o_ff || rsp_chan.ready;
   assign free_d = !v_d_ff || free_o;
   assign free_s = !v_s_ff || free_d;
   assign free_f = !v_f_ff || free_s;
   assign free_g = !v_g_ff || free_f;
   assign free_p = !v_p_ff || free_g;

   assign req_chan.ready = free_p;
   assign rsp_chan.valid = v_o_ff;

   assign fir_ctrl = '{
      load_p: req_chan.valid && free_p,
      en_p:   free_p,
      en_g:   free_g,
      en_f:   free_f
   };

   assign mean_ctrl = '{
      load_s: v_f_ff && free_s,
      en_s:   free_s,
      en_d:   free_d,
      en_o:   free_o
   };

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_p_ff <= 1'b0;
         v_g_ff <= 1'b0;
         v_f_ff <= 1'b0;
         v_s_ff <= 1'b0;
         v_d_ff <= 1'b0;
         v_o_ff <= 1'b0;
      end else begin
         v_p_ff <= free_p ? req_chan.valid : 1'b1;
         v_g_ff <= free_g ? v_p_ff : 1'b1;
         v_f_ff <= free_f ? v_g_ff : 1'b1;
         v_s_ff <= free_s ? v_f_ff : 1'b1;
         v_d_ff <= free_d ? v_s_ff : 1'b1;
         v_o_ff <= free_o ? v_d_ff : 1'b1;
      end
   end

   // window position and first-pass flag
   assign pos_in = (pos_ff == LAST_POS) ? '0 : (pos_ff + POS_W'(1));
   assign rd_pos = mean_ctrl.load_s ? pos_in : pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         wrapped_ff <= 1'b0;
      end else if (mean_ctrl.load_s) begin
         pos_ff <= pos_in;
         if (pos_ff == LAST_POS) begin
            wrapped_ff <= 1'b1;
         end
      end
   end

   // filter per channel
   emgenv_fir u_fir_one (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (fir_ctrl),
      .sample     (req_chan.sample_ch1),
      .sample_ref (req_chan.sample_ref),
      .filt       (filt_one)
   );

   emgenv_fir u_fir_two (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (fir_ctrl),
      .sample     (req_chan.sample_ch2),
      .sample_ref (req_chan.sample_ref),
      .filt       (filt_two)
   );

   // moving mean per channel, sharing the window position
   emgenv_mean u_mean_one (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mean_ctrl),
      .filt     (filt_one),
      .wr_pos   (pos_ff),
      .rd_pos   (rd_pos),
      .wrapped  (wrapped_ff),
      .envelope (rsp_chan.envelope_ch1)
   );

   emgenv_mean u_mean_two (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mean_ctrl),
      .filt     (filt_two),
      .wr_pos   (pos_ff),
      .rd_pos   (rd_pos),
      .wrapped  (wrapped_ff),
      .envelope (rsp_chan.envelope_ch2)
   );

   // checks
   a_first_pass_ends_at_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(wrapped_ff) |-> (pos_ff == '0))
      else $error("window wrap flag set away from slot zero");

   a_output_fed_by_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(v_o_ff) |-> $past(v_d_ff))
      else $error("result word appeared without a word in the stage before");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |->
         !(v_p_ff && v_g_ff && v_f_ff && v_s_ff && v_d_ff && v_o_ff && !rsp_chan.ready))
      else $error("word accepted while every stage is full and stalled");

   a_window_advance_one: assert property (@(posedge clock) disable iff (reset)
      $past(mean_ctrl.load_s) && !$past(reset) |->
         (pos_ff == $past(pos_in)))
      else $error("window position did not advance by one slot");
endmodule

// ----- tb/emgenv_checker.sv -----
`timescale 1ns / 1ps
// envelope checker: watches both channels, predicts each result word and compares it
module emgenv_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [emgenv_pkg::SAMPLE_W-1:0] req_sample_ch1,
   input  logic [emgenv_pkg::SAMPLE_W-1:0] req_sample_ch2,
   input  logic [emgenv_pkg::SAMPLE_W-1:0] req_sample_ref,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [emgenv_pkg::FILT_W-1:0]   rsp_envelope_ch1,
   input  logic [emgenv_pkg::FILT_W-1:0]   rsp_envelope_ch2,
   output int                              fail_count,
   output int                              pending
);
   import emgenv_pkg::*;

   localparam int FILT_SHIFT = 27;
   localparam int FILT_MAX   = 65535;

   typedef struct packed {
      logic [FILT_W-1:0] ch1;
      logic [FILT_W-1:0] ch2;
   } envelope_pair_type;

   // predictor state, index 0 is channel one
   logic [SAMPLE_W-1:0] magnitude_line  [2][TAP_COUNT];
   logic [FILT_W-1:0]   filtered_window [2][WINDOW_LENGTH];
   int unsigned         window_sum      [2];
   int unsigned         window_slot;

   envelope_pair_type envelope_due [$];
   envelope_pair_type want;

   // shift one magnitude into a channel's tap line and return the rounded 12.4 output
   function automatic logic [FILT_W-1:0] filter_push(input int ch,
                                                     input logic [SAMPLE_W-1:0] mag);
      longint unsigned acc;
      longint unsigned rounded;
      int k;
      for (k = TAP_COUNT - 1; k > 0; k--) begin
         magnitude_line[ch][k] = magnitude_line[ch][k-1];
      end
      magnitude_line[ch][0] = mag;
      acc = 0;
      for (k = 0; k < TAP_COUNT; k++) begin
         if (k < COEF_TABLE_LEN) begin
            acc += 64'(magnitude_line[ch][k]) * 64'(LOWPASS_Q31[k]);
         end
      end
      rounded = (acc + (64'd1 << (FILT_SHIFT - 1))) >> FILT_SHIFT;
      return (rounded > FILT_MAX) ? FILT_W'(FILT_MAX) : rounded[FILT_W-1:0];
   endfunction

   // one sample tick: rectify, filter, then moving mean for both channels
   function automatic envelope_pair_type envelope_step(input logic [SAMPLE_W-1:0] s1,
                                                       input logic [SAMPLE_W-1:0] s2,
                                                       input logic [SAMPLE_W-1:0] sr);
      logic [SAMPLE_W-1:0] mag   [2];
      logic [FILT_W-1:0]   filt  [2];
      int unsigned         mean  [2];
      envelope_pair_type   pair;
      int ch;
      mag[0] = (s1 >= sr) ? s1 - sr : sr - s1;
      mag[1] = (s2 >= sr) ? s2 - sr : sr - s2;
      for (ch = 0; ch < 2; ch++) begin
         filt[ch] = filter_push(ch, mag[ch]);
         window_sum[ch] = window_sum[ch] - filtered_window[ch][window_slot] + filt[ch];
         filtered_window[ch][window_slot] = filt[ch];
         mean[ch] = (window_sum[ch] + WINDOW_LENGTH / 2) / WINDOW_LENGTH;
         if (mean[ch] > FILT_MAX) begin
            mean[ch] = FILT_MAX;
         end
      end
      window_slot = (window_slot == WINDOW_LENGTH - 1) ? 0 : window_slot + 1;
      pair.ch1 = mean[0][FILT_W-1:0];
      pair.ch2 = mean[1][FILT_W-1:0];
      return pair;
   endfunction

   // watch both channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         for (int ch = 0; ch < 2; ch++) begin
            for (int k = 0; k < TAP_COUNT; k++) begin
               magnitude_line[ch][k] = '0;
            end
            for (int k = 0; k < WINDOW_LENGTH; k++) begin
               filtered_window[ch][k] = '0;
            end
            window_sum[ch] = 0;
         end
         window_slot = 0;
         envelope_due.delete();
         fail_count = 0;
      end else begin
         // result side
         if (rsp_valid && rsp_ready) begin
            if (envelope_due.size() == 0) begin
               $error("envelope word with none expected: ch1 %0d ch2 %0d",
                      rsp_envelope_ch1, rsp_envelope_ch2);
               fail_count++;
            end else begin
               want = envelope_due.pop_front();
               if (rsp_envelope_ch1 !== want.ch1) begin
                  $error("envelope_ch1 mismatch: expected %0d, actual %0d",
                         want.ch1, rsp_envelope_ch1);
                  fail_count++;
               end
               if (rsp_envelope_ch2 !== want.ch2) begin
                  $error("envelope_ch2 mismatch: expected %0d, actual %0d",
                         want.ch2, rsp_envelope_ch2);
                  fail_count++;
               end
            end
         end
         // input side
         if (req_valid && req_ready) begin
            envelope_due.push_back(envelope_step(req_sample_ch1, req_sample_ch2,
                                                 req_sample_ref));
         end
      end
      pending = envelope_due.size();
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// testbench top: sample stimulus, result pacing, watchdog and verdict for the envelope block
module tb;
   import emgenv_pkg::*;

   localparam int IDLE_LIMIT      = 5000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_WORDS     = 460;
   localparam int DRAIN_CYCLES    = 20;
   localparam int ADC_TOP         = (1 << SAMPLE_W) - 1;

   typedef enum int {
      SEG_FULL_RANGE,
      SEG_NEAR_REF,
      SEG_MAX_SWING,
      SEG_STEADY
   } segment_kind_type;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   hold_off_request;
   int   idle_cycles;
   int   phase_words;

   emgenv_req_if req_chan ();
   emgenv_rsp_if rsp_chan ();

   emg_envelope_two_channel i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   emgenv_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_sample_ch1   (req_chan.sample_ch1),
      .req_sample_ch2   (req_chan.sample_ch2),
      .req_sample_ref   (req_chan.sample_ref),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_envelope_ch1 (rsp_chan.envelope_ch1),
      .rsp_envelope_ch2 (rsp_chan.envelope_ch2),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // offer one sample word, with random gaps in front, and wait until it is taken
   task automatic send_word(input logic [SAMPLE_W-1:0] s1, input logic [SAMPLE_W-1:0] s2,
                            input logic [SAMPLE_W-1:0] sr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.sample_ch1 <= s1;
      req_chan.sample_ch2 <= s2;
      req_chan.sample_ref <= sr;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      phase_words++;
   endtask

   // keep a sample within the adc range
   function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
      if (v < 0) begin
         return '0;
      end
      if (v > ADC_TOP) begin
         return SAMPLE_W'(ADC_TOP);
      end
      return SAMPLE_W'(v);
   endfunction

   // a run of words of one character: wide noise, small signal, full swing or held level
   task automatic send_segment(input segment_kind_type kind, input int count);
      logic [SAMPLE_W-1:0] s1, s2, sr;
      int i;
      s1 = SAMPLE_W'($urandom_range(ADC_TOP));
      s2 = SAMPLE_W'($urandom_range(ADC_TOP));
      sr = SAMPLE_W'($urandom_range(ADC_TOP));
      for (i = 0; i < count; i++) begin
         case (kind)
            SEG_FULL_RANGE: begin
               s1 = SAMPLE_W'($urandom_range(ADC_TOP));
               s2 = SAMPLE_W'($urandom_range(ADC_TOP));
               sr = SAMPLE_W'($urandom_range(ADC_TOP));
            end
            SEG_NEAR_REF: begin
               sr = SAMPLE_W'($urandom_range(ADC_TOP));
               s1 = clamp_sample(int'(sr) + $urandom_range(40) - 20);
               s2 = clamp_sample(int'(sr) + $urandom_range(40) - 20);
            end
            SEG_MAX_SWING: begin
               sr = $urandom_range(1) ? SAMPLE_W'(ADC_TOP) : '0;
               s1 = ~sr;
               s2 = $urandom_range(3) == 0 ? SAMPLE_W'($urandom_range(ADC_TOP)) : ~sr;
            end
            default: begin
               // held level: keep the values drawn at the start
            end
         endcase
         send_word(s1, s2, sr);
      end
   endtask

   // random words until the phase has its share
   task automatic run_phase(input int target, input bit with_hold_off);
      segment_kind_type kind;
      phase_words = 0;
      while (phase_words < target) begin
         if (with_hold_off && phase_words >= 100 && hold_off_request == 0) begin
            hold_off_request++;
         end
         kind = segment_kind_type'($urandom_range(3));
         send_segment(kind, $urandom_range(10, 60));
      end
   endtask

   // result side pacing, with one long hold-off on request
   initial begin
      int stall_left;
      int hold_off_seen;
      stall_left    = 0;
      hold_off_seen = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request != hold_off_seen) begin
            hold_off_seen = hold_off_request;
            stall_left    = HOLD_OFF_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // reset, directed words, three random phases, drain and verdict
   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.sample_ch1 = '0;
      req_chan.sample_ch2 = '0;
      req_chan.sample_ref = '0;
      send_idle_pct       = 12;
      recv_idle_pct       = 52;
      hold_off_request    = 0;
      phase_words         = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // field extremes, reference above and below the electrodes
      send_word('0, '0, '0);
      send_word(SAMPLE_W'(ADC_TOP), SAMPLE_W'(ADC_TOP), SAMPLE_W'(ADC_TOP));
      send_word(SAMPLE_W'(ADC_TOP), '0, '0);
      send_word('0, SAMPLE_W'(ADC_TOP), SAMPLE_W'(ADC_TOP));
      send_word('0, SAMPLE_W'(ADC_TOP), '0);
      send_word(SAMPLE_W'(ADC_TOP), '0, SAMPLE_W'(ADC_TOP));
      // full-scale magnitude on both channels to push the filter towards its top
      for (int i = 0; i < 19; i++) begin
         if (i % 2 == 0) begin
            send_word(SAMPLE_W'(ADC_TOP), SAMPLE_W'(ADC_TOP), '0);
         end else begin
            send_word('0, '0, SAMPLE_W'(ADC_TOP));
         end
      end

      run_phase(PHASE_WORDS, 1'b0);
      send_idle_pct = 52;
      recv_idle_pct = 12;
      run_phase(PHASE_WORDS, 1'b0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(PHASE_WORDS, 1'b1);

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
